// ----- hdl/fdctl_pkg.sv -----
// fdctl_pkg: shared types, codes and constants of the floppy drive control logic
// no dependencies; used by every module of the block

package fdctl_pkg;

    localparam int MAX_CYLINDER_DEF = 83;
    localparam int STEP_SETTLE_DEF  = 1060;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 25;
    localparam int ELAPSED_W   = 25;
    localparam int STEP_W      = 11;
    localparam int CYL_W       = 7;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [STEP_W-1:0]    STEP_MAX    = '1;

    localparam logic [ELAPSED_W-1:0] START_DELAY_RST = 25'd10782500;
    localparam logic [ELAPSED_W-1:0] STOP_DELAY_RST  = 25'd2270000;

    localparam logic [31:0] POLL_SIG0 = 32'h0100_0100;
    localparam logic [31:0] POLL_SIG1 = 32'h0001_0001;
    localparam logic [31:0] POLL_SIG2 = 32'h0203_0203;
    localparam logic [31:0] POLL_SIG3 = 32'h0302_0302;

    typedef enum logic [1:0] {
        CMD_PORT_WRITE = 2'd0,
        CMD_TICKS      = 2'd1,
        CMD_INSERT     = 2'd2,
        CMD_EJECT      = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DRIVE_NUMBER      = 8'd0,
        REG_MECHANICS_ENABLED = 8'd1,
        REG_START_DELAY       = 8'd2,
        REG_STOP_DELAY        = 8'd3
    } reg_index_t;

    // port bit positions
    localparam int PORT_MTR  = 7;
    localparam int PORT_SEL0 = 3;
    localparam int PORT_SIDE = 2;
    localparam int PORT_DIR  = 1;
    localparam int PORT_STEP = 0;

    typedef struct packed {
        logic [1:0]           drive_number;
        logic                 mechanics_enabled;
        logic [ELAPSED_W-1:0] start_delay;
        logic [ELAPSED_W-1:0] stop_delay;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  port_value;
        logic [15:0] tick_count;
        logic        write_protect;
    } item_t;

    typedef struct packed {
        logic [7:0]       status_flags;
        logic [CYL_W-1:0] cylinder;
        logic             side;
        logic             motor_on;
        logic             motor_full;
        logic             head_stepped;
        logic             head_poll;
    } result_t;

    function automatic logic speed_is_full(
        input logic                 motor,
        input logic                 full_at_switch,
        input logic [ELAPSED_W-1:0] elapsed,
        input logic [ELAPSED_W-1:0] start_delay,
        input logic [ELAPSED_W-1:0] stop_delay
    );
        logic r;
        if (motor)
        begin
            r = (start_delay == '0) || full_at_switch || (elapsed >= start_delay);
        end
        else
        begin
            r = (stop_delay != '0) && full_at_switch && (elapsed < stop_delay);
        end
        return r;
    endfunction

endpackage

// ----- hdl/fdctl_cfg.sv -----
// fdctl_cfg: configuration register file written over the cfg channel
// depends on fdctl_pkg

module fdctl_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_fire,
    input  logic [fdctl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fdctl_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fdctl_pkg::cfg_t                    cfg
);

    fdctl_pkg::cfg_t cfg_reg;
    fdctl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                fdctl_pkg::REG_DRIVE_NUMBER:      cfg_next.drive_number = cfg_data[1:0];
                fdctl_pkg::REG_MECHANICS_ENABLED: cfg_next.mechanics_enabled = cfg_data[0];
                fdctl_pkg::REG_START_DELAY:       cfg_next.start_delay = cfg_data;
                fdctl_pkg::REG_STOP_DELAY:        cfg_next.stop_delay = cfg_data;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_number      <= 2'd0;
            cfg_reg.mechanics_enabled <= 1'b1;
            cfg_reg.start_delay       <= fdctl_pkg::START_DELAY_RST;
            cfg_reg.stop_delay        <= fdctl_pkg::STOP_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/fdctl_core.sv -----
// fdctl_core: drive state registers and the single-pass update for one transaction
// depends on fdctl_pkg

module fdctl_core
#(
    parameter int MAX_CYLINDER = fdctl_pkg::MAX_CYLINDER_DEF,
    parameter int STEP_SETTLE  = fdctl_pkg::STEP_SETTLE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  fdctl_pkg::item_t    item,
    input  fdctl_pkg::cfg_t     cfg,
    output fdctl_pkg::result_t  result
);

    localparam int EW = fdctl_pkg::ELAPSED_W;
    localparam int SW = fdctl_pkg::STEP_W;
    localparam int CW = fdctl_pkg::CYL_W;
    localparam logic [CW-1:0] MAX_CYL = CW'(MAX_CYLINDER);
    localparam logic [SW-1:0] SETTLE  = SW'(STEP_SETTLE);
    localparam logic [SW-1:0] STEP_RST =
        (STEP_SETTLE + 1 > 2047) ? fdctl_pkg::STEP_MAX : SW'(STEP_SETTLE + 1);

    logic [7:0]    last_port_reg,     last_port_next;
    logic [CW-1:0] cyl_reg,           cyl_next;
    logic          side_reg,          side_next;
    logic          motor_reg,         motor_next;
    logic          full_reg,          full_next;
    logic [EW-1:0] motor_el_reg,      motor_el_next;
    logic [SW-1:0] step_el_reg,       step_el_next;
    logic [4:0]    id_count_reg,      id_count_next;
    logic          id_bit_reg,        id_bit_next;
    logic          present_reg,       present_next;
    logic          protected_reg,     protected_next;
    logic          change_reg,        change_next;
    logic [31:0]   history_reg,       history_next;

    logic [2:0]    sel_idx;
    logic          old_sel, new_sel, old_mtr, new_mtr, old_step, new_step, dir;
    logic          motor_req, step_ok, stepped, poll, full_out, selected;
    logic [EW:0]   motor_sum;
    logic [16:0]   step_sum;
    logic [7:0]    status;

    assign sel_idx   = 3'(fdctl_pkg::PORT_SEL0) + {1'b0, cfg.drive_number};
    assign old_sel   = last_port_reg[sel_idx];
    assign new_sel   = item.port_value[sel_idx];
    assign old_mtr   = last_port_reg[fdctl_pkg::PORT_MTR];
    assign new_mtr   = item.port_value[fdctl_pkg::PORT_MTR];
    assign old_step  = last_port_reg[fdctl_pkg::PORT_STEP];
    assign new_step  = item.port_value[fdctl_pkg::PORT_STEP];
    assign dir       = item.port_value[fdctl_pkg::PORT_DIR];
    assign motor_req = !old_mtr || !new_mtr;
    assign step_ok   = !cfg.mechanics_enabled || (step_el_reg > SETTLE) ||
                       (step_el_reg == fdctl_pkg::STEP_MAX);
    assign motor_sum = {1'b0, motor_el_reg} + (EW+1)'(item.tick_count);
    assign step_sum  = 17'(step_el_reg) + {1'b0, item.tick_count};

    always_comb
    begin
        last_port_next = last_port_reg;
        cyl_next       = cyl_reg;
        side_next      = side_reg;
        motor_next     = motor_reg;
        full_next      = full_reg;
        motor_el_next  = motor_el_reg;
        step_el_next   = step_el_reg;
        id_count_next  = id_count_reg;
        id_bit_next    = id_bit_reg;
        present_next   = present_reg;
        protected_next = protected_reg;
        change_next    = change_reg;
        history_next   = history_reg;
        stepped        = 1'b0;
        poll           = 1'b0;

        unique case (fdctl_pkg::cmd_t'(item.command))
            fdctl_pkg::CMD_PORT_WRITE:
            begin
                last_port_next = item.port_value;
                if (old_sel && !new_sel)
                begin
                    id_count_next = id_count_reg + 5'd1;
                    id_bit_next   = (cfg.drive_number != 2'd0);
                    if (motor_reg != motor_req)
                    begin
                        full_next     = fdctl_pkg::speed_is_full(motor_reg, full_reg,
                                            motor_el_reg, cfg.start_delay, cfg.stop_delay);
                        motor_el_next = '0;
                        motor_next    = motor_req;
                        id_count_next = 5'd0;
                    end
                end
                if (!old_step && new_step && !old_sel)
                begin
                    if (present_reg)
                    begin
                        change_next = 1'b1;
                    end
                    if (step_ok)
                    begin
                        if (dir && cyl_reg != '0)
                        begin
                            cyl_next     = cyl_reg - CW'(1);
                            history_next = {history_reg[23:0], 1'b0, cyl_next};
                        end
                        else if (!dir && cyl_reg < MAX_CYL)
                        begin
                            cyl_next     = cyl_reg + CW'(1);
                            history_next = {history_reg[23:0], 1'b0, cyl_next};
                        end
                        stepped      = 1'b1;
                        poll         = !present_reg && (history_next == fdctl_pkg::POLL_SIG0 ||
                                       history_next == fdctl_pkg::POLL_SIG1 ||
                                       history_next == fdctl_pkg::POLL_SIG2 ||
                                       history_next == fdctl_pkg::POLL_SIG3);
                        step_el_next = '0;
                    end
                end
                side_next = !item.port_value[fdctl_pkg::PORT_SIDE];
            end
            fdctl_pkg::CMD_TICKS:
            begin
                motor_el_next = motor_sum[EW] ? fdctl_pkg::ELAPSED_MAX : motor_sum[EW-1:0];
                step_el_next  = (step_sum > 17'(fdctl_pkg::STEP_MAX)) ?
                                fdctl_pkg::STEP_MAX : step_sum[SW-1:0];
            end
            fdctl_pkg::CMD_INSERT:
            begin
                if (!present_reg)
                begin
                    present_next   = 1'b1;
                    protected_next = item.write_protect;
                end
            end
            fdctl_pkg::CMD_EJECT:
            begin
                if (present_reg)
                begin
                    change_next    = 1'b0;
                    present_next   = 1'b0;
                    protected_next = 1'b0;
                end
            end
        endcase
    end

    // status after the transaction has taken effect
    always_comb
    begin
        full_out = fdctl_pkg::speed_is_full(motor_next, full_next, motor_el_next,
                                            cfg.start_delay, cfg.stop_delay);
        selected = !last_port_next[sel_idx];
        status   = 8'hFF;
        if (selected)
        begin
            if ((!full_out && id_bit_next) || (full_out && present_next))
            begin
                status[5] = 1'b0;
            end
            if (cyl_next == '0)
            begin
                status[4] = 1'b0;
            end
            if (!present_next || protected_next)
            begin
                status[3] = 1'b0;
            end
            if (!change_next)
            begin
                status[2] = 1'b0;
            end
        end
        result.status_flags = status;
        result.cylinder     = cyl_next;
        result.side         = side_next;
        result.motor_on     = motor_next;
        result.motor_full   = full_out;
        result.head_stepped = stepped;
        result.head_poll    = poll;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_port_reg <= 8'hFF;
            cyl_reg       <= '0;
            side_reg      <= 1'b0;
            motor_reg     <= 1'b0;
            full_reg      <= 1'b0;
            motor_el_reg  <= '0;
            step_el_reg   <= STEP_RST;
            id_count_reg  <= 5'd0;
            id_bit_reg    <= 1'b0;
            present_reg   <= 1'b0;
            protected_reg <= 1'b0;
            change_reg    <= 1'b0;
            history_reg   <= '0;
        end
        else if (fire)
        begin
            last_port_reg <= last_port_next;
            cyl_reg       <= cyl_next;
            side_reg      <= side_next;
            motor_reg     <= motor_next;
            full_reg      <= full_next;
            motor_el_reg  <= motor_el_next;
            step_el_reg   <= step_el_next;
            id_count_reg  <= id_count_next;
            id_bit_reg    <= id_bit_next;
            present_reg   <= present_next;
            protected_reg <= protected_next;
            change_reg    <= change_next;
            history_reg   <= history_next;
        end
    end

endmodule

// ----- hdl/floppy_drive_control_logic.sv -----
// floppy_drive_control_logic: top level with input register, drive core and result register
// depends on fdctl_pkg, fdctl_cfg, fdctl_core
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | command, port_value, tick_count, write_protect
//   out     | output    | out_valid / out_ready| status_flags, cylinder, side, motor_on,
//           |           |                      | motor_full, head_stepped, head_poll
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one transaction per cycle sustained unless the output stalls; the result is registered
// the state update is combinational between the input register and the result register
// reset returns all drive state and the registers to their defaults; no clearing pass
// a stalled result holds the core; the input register still takes one more transaction
// cfg_ready is always high; an index beyond the register list is ignored

module floppy_drive_control_logic
#(
    parameter int MAX_CYLINDER = fdctl_pkg::MAX_CYLINDER_DEF,
    parameter int STEP_SETTLE  = fdctl_pkg::STEP_SETTLE_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         command,
    input  logic [7:0]                         port_value,
    input  logic [15:0]                        tick_count,
    input  logic                               write_protect,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         status_flags,
    output logic [fdctl_pkg::CYL_W-1:0]        cylinder,
    output logic                               side,
    output logic                               motor_on,
    output logic                               motor_full,
    output logic                               head_stepped,
    output logic                               head_poll,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fdctl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fdctl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    fdctl_pkg::cfg_t    cfg;
    fdctl_pkg::item_t   item_reg;
    fdctl_pkg::result_t core_result;
    fdctl_pkg::result_t result_reg;
    logic               in_vld_reg, in_vld_next;
    logic               out_vld_reg, out_vld_next;
    logic               process;

    assign cfg_ready = 1'b1;
    assign process   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || process;

    fdctl_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fdctl_core
    #(
        .MAX_CYLINDER (MAX_CYLINDER),
        .STEP_SETTLE  (STEP_SETTLE)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (process),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (process)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (process)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{command: command, port_value: port_value,
                          tick_count: tick_count, write_protect: write_protect};
        end
        if (process)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid    = out_vld_reg;
    assign status_flags = result_reg.status_flags;
    assign cylinder     = result_reg.cylinder;
    assign side         = result_reg.side;
    assign motor_on     = result_reg.motor_on;
    assign motor_full   = result_reg.motor_full;
    assign head_stepped = result_reg.head_stepped;
    assign head_poll    = result_reg.head_poll;

endmodule

// ----- hdl/fdctl_checker.sv -----
// fdctl_checker: port-level assertions on the floppy drive control logic, and its bind
// depends on fdctl_pkg and floppy_drive_control_logic

module fdctl_checker
#(
    parameter int MAX_CYLINDER = fdctl_pkg::MAX_CYLINDER_DEF
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [7:0]                  status_flags,
    input logic [fdctl_pkg::CYL_W-1:0] cylinder,
    input logic                        head_stepped,
    input logic                        head_poll
);

    localparam logic [fdctl_pkg::CYL_W-1:0] MAX_CYL = fdctl_pkg::CYL_W'(MAX_CYLINDER);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status_flags) && $stable(cylinder))
        else $error("stalled result changed");

    // polling only flagged on an accepted step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && head_poll |-> head_stepped)
        else $error("head_poll without head_stepped");

    // unused status bits stay high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status_flags[7:6] == 2'b11 && status_flags[1:0] == 2'b11)
        else $error("reserved status bits low");

    // track zero bit agrees with cylinder when selected
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_flags != 8'hFF |-> status_flags[4] == (cylinder != '0))
        else $error("track zero bit mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cylinder <= MAX_CYL)
        else $error("cylinder beyond limit");

endmodule

bind floppy_drive_control_logic fdctl_checker
#(
    .MAX_CYLINDER (MAX_CYLINDER)
)
u_fdctl_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status_flags (status_flags),
    .cylinder     (cylinder),
    .head_stepped (head_stepped),
    .head_poll    (head_poll)
);

// ----- verif/tb_floppy_drive_control_logic.sv -----
`timescale 1ns / 100ps
// tb_floppy_drive_control_logic: self-checking testbench of the floppy drive control logic
// depends on fdctl_pkg and floppy_drive_control_logic; predicts every result and compares it

module tb_floppy_drive_control_logic;

    localparam int IDLE_PCT       = 38;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_RST     = (fdctl_pkg::STEP_SETTLE_DEF + 1 > 2047) ? 2047 :
                                    fdctl_pkg::STEP_SETTLE_DEF + 1;

    localparam int CYL_W       = fdctl_pkg::CYL_W;
    localparam int CFG_INDEX_W = fdctl_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = fdctl_pkg::CFG_DATA_W;
    localparam int ELAPSED_W   = fdctl_pkg::ELAPSED_W;
    localparam int STEP_W      = fdctl_pkg::STEP_W;

    // status byte bits, active low
    localparam int ST_READY_BIT   = 5;
    localparam int ST_TRACK0_BIT  = 4;
    localparam int ST_PROTECT_BIT = 3;
    localparam int ST_CHANGE_BIT  = 2;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_ready;
    logic [1:0]             command       = '0;
    logic [7:0]             port_value    = '0;
    logic [15:0]            tick_count    = '0;
    logic                   write_protect = 1'b0;
    logic                   out_valid;
    logic                   out_ready     = 1'b0;
    logic [7:0]             status_flags;
    logic [CYL_W-1:0]       cylinder;
    logic                   side;
    logic                   motor_on;
    logic                   motor_full;
    logic                   head_stepped;
    logic                   head_poll;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    floppy_drive_control_logic u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .port_value    (port_value),
        .tick_count    (tick_count),
        .write_protect (write_protect),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status_flags  (status_flags),
        .cylinder      (cylinder),
        .side          (side),
        .motor_on      (motor_on),
        .motor_full    (motor_full),
        .head_stepped  (head_stepped),
        .head_poll     (head_poll),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // drive model: configuration and state
    logic [1:0]           drv_sel;
    logic                 mech_on;
    logic [ELAPSED_W-1:0] spin_up;
    logic [ELAPSED_W-1:0] spin_down;
    logic [7:0]           port_q;
    logic [CYL_W-1:0]     head_cyl;
    logic                 head_sd;
    logic                 motor_q;
    logic                 full_q;
    logic [ELAPSED_W-1:0] motor_ticks;
    logic [STEP_W-1:0]    settle_ticks;
    logic [4:0]           id_cnt;
    logic                 id_q;
    logic                 disk_in;
    logic                 disk_wp;
    logic                 disk_chg;
    logic [31:0]          cyl_hist;

    fdctl_pkg::result_t pending_results[$];
    int      items_sent   = 0;
    int      results_seen = 0;
    int      error_count  = 0;
    int      idle_cycles  = 0;
    bit      gaps_on      = 1'b1;

    task automatic reset_drive_model();
        drv_sel      = '0;
        mech_on      = 1'b1;
        spin_up      = fdctl_pkg::START_DELAY_RST;
        spin_down    = fdctl_pkg::STOP_DELAY_RST;
        port_q       = 8'hFF;
        head_cyl     = '0;
        head_sd      = 1'b0;
        motor_q      = 1'b0;
        full_q       = 1'b0;
        motor_ticks  = '0;
        settle_ticks = STEP_W'(SETTLE_RST);
        id_cnt       = '0;
        id_q         = 1'b0;
        disk_in      = 1'b0;
        disk_wp      = 1'b0;
        disk_chg     = 1'b0;
        cyl_hist     = '0;
    endtask

    function automatic logic spin_full();
        if (motor_q)
            return (spin_up == '0) || full_q || (motor_ticks >= spin_up);
        return (spin_down != '0) && full_q && (motor_ticks < spin_down);
    endfunction

    task automatic switch_motor(input logic on);
        if (motor_q != on)
        begin
            full_q      = spin_full();
            motor_ticks = '0;
            motor_q     = on;
            id_cnt      = '0;
        end
    endtask

    function automatic logic [7:0] status_of();
        logic [7:0] s;
        s = 8'hFF;
        if (port_q[fdctl_pkg::PORT_SEL0 + drv_sel] == 1'b0)
        begin
            if (!spin_full())
            begin
                if (id_q)
                    s[ST_READY_BIT] = 1'b0;
            end
            else if (disk_in)
            begin
                s[ST_READY_BIT] = 1'b0;
            end
            if (head_cyl == '0)
                s[ST_TRACK0_BIT] = 1'b0;
            if (!disk_in || disk_wp)
                s[ST_PROTECT_BIT] = 1'b0;
            if (!disk_chg)
                s[ST_CHANGE_BIT] = 1'b0;
        end
        return s;
    endfunction

    task automatic predict_drive(input fdctl_pkg::item_t it, output fdctl_pkg::result_t r);
        logic sel_was, sel_now, mtr_was, mtr_now, step_was, step_now, settled;
        logic stepped, poll;
        stepped = 1'b0;
        poll    = 1'b0;
        unique case (it.command)
            fdctl_pkg::CMD_PORT_WRITE:
            begin
                sel_was  = port_q[fdctl_pkg::PORT_SEL0 + drv_sel];
                sel_now  = it.port_value[fdctl_pkg::PORT_SEL0 + drv_sel];
                mtr_was  = port_q[fdctl_pkg::PORT_MTR];
                mtr_now  = it.port_value[fdctl_pkg::PORT_MTR];
                step_was = port_q[fdctl_pkg::PORT_STEP];
                step_now = it.port_value[fdctl_pkg::PORT_STEP];
                port_q   = it.port_value;
                if (sel_was && !sel_now)
                begin
                    id_cnt = id_cnt + 5'd1;
                    id_q   = (drv_sel != '0);
                    switch_motor(!mtr_was || !mtr_now);
                end
                if (!step_was && step_now && !sel_was)
                begin
                    if (disk_in)
                        disk_chg = 1'b1;
                    settled = !mech_on || (settle_ticks > fdctl_pkg::STEP_SETTLE_DEF) ||
                              (settle_ticks == fdctl_pkg::STEP_MAX);
                    if (settled)
                    begin
                        if (it.port_value[fdctl_pkg::PORT_DIR])
                        begin
                            if (head_cyl > 0)
                            begin
                                head_cyl = head_cyl - 1'b1;
                                cyl_hist = {cyl_hist[23:0], 1'b0, head_cyl};
                            end
                        end
                        else if (head_cyl < fdctl_pkg::MAX_CYLINDER_DEF)
                        begin
                            head_cyl = head_cyl + 1'b1;
                            cyl_hist = {cyl_hist[23:0], 1'b0, head_cyl};
                        end
                        stepped = 1'b1;
                        poll = !disk_in && ((cyl_hist == fdctl_pkg::POLL_SIG0) ||
                                            (cyl_hist == fdctl_pkg::POLL_SIG1) ||
                                            (cyl_hist == fdctl_pkg::POLL_SIG2) ||
                                            (cyl_hist == fdctl_pkg::POLL_SIG3));
                        settle_ticks = '0;
                    end
                end
                head_sd = !it.port_value[fdctl_pkg::PORT_SIDE];
            end
            fdctl_pkg::CMD_TICKS:
            begin
                if (fdctl_pkg::ELAPSED_MAX - motor_ticks < it.tick_count)
                    motor_ticks = fdctl_pkg::ELAPSED_MAX;
                else
                    motor_ticks = motor_ticks + ELAPSED_W'(it.tick_count);
                if (16'(fdctl_pkg::STEP_MAX - settle_ticks) < it.tick_count)
                    settle_ticks = fdctl_pkg::STEP_MAX;
                else
                    settle_ticks = settle_ticks + STEP_W'(it.tick_count);
            end
            fdctl_pkg::CMD_INSERT:
            begin
                if (!disk_in)
                begin
                    disk_in = 1'b1;
                    disk_wp = it.write_protect;
                end
            end
            fdctl_pkg::CMD_EJECT:
            begin
                if (disk_in)
                begin
                    disk_chg = 1'b0;
                    disk_in  = 1'b0;
                    disk_wp  = 1'b0;
                end
            end
        endcase
        r.status_flags = status_of();
        r.cylinder     = head_cyl;
        r.side         = head_sd;
        r.motor_on     = motor_q;
        r.motor_full   = spin_full();
        r.head_stepped = stepped;
        r.head_poll    = poll;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        fdctl_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no transaction pending",
                                          results_seen));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status_flags", status_flags, want.status_flags);
                check_field("cylinder", 8'(cylinder), 8'(want.cylinder));
                check_field("side", 8'(side), 8'(want.side));
                check_field("motor_on", 8'(motor_on), 8'(want.motor_on));
                check_field("motor_full", 8'(motor_full), 8'(want.motor_full));
                check_field("head_stepped", 8'(head_stepped), 8'(want.head_stepped));
                check_field("head_poll", 8'(head_poll), 8'(want.head_poll));
            end
            results_seen++;
        end
        out_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] pv,
                             input logic [15:0] tc, input logic wp);
        fdctl_pkg::item_t   it;
        fdctl_pkg::result_t want;
        it.command       = cmd;
        it.port_value    = pv;
        it.tick_count    = tc;
        it.write_protect = wp;
        while (gaps_on && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        port_value    <= pv;
        tick_count    <= tc;
        write_protect <= wp;
        do
            @(posedge clk);
        while (!in_ready);
        predict_drive(it, want);
        pending_results.push_back(want);
        items_sent++;
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            fdctl_pkg::REG_DRIVE_NUMBER:      drv_sel   = data[1:0];
            fdctl_pkg::REG_MECHANICS_ENABLED: mech_on   = data[0];
            fdctl_pkg::REG_START_DELAY:       spin_up   = data;
            fdctl_pkg::REG_STOP_DELAY:        spin_down = data;
            default: ;
        endcase
    endtask

    // every change also writes an index past the register list, which must be ignored
    task automatic set_config(input logic [CFG_DATA_W-1:0] drive_data, input logic mech,
                              input logic [ELAPSED_W-1:0] up, input logic [ELAPSED_W-1:0] down);
        wait_results_done();
        write_reg(CFG_INDEX_W'($urandom_range(255, fdctl_pkg::REG_STOP_DELAY + 1)),
                  CFG_DATA_W'($urandom));
        write_reg(fdctl_pkg::REG_DRIVE_NUMBER, drive_data);
        write_reg(fdctl_pkg::REG_MECHANICS_ENABLED, {{(CFG_DATA_W-1){1'b0}}, mech});
        write_reg(fdctl_pkg::REG_START_DELAY, up);
        write_reg(fdctl_pkg::REG_STOP_DELAY, down);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] port_byte(input logic mtr, input logic sel, input logic sd,
                                             input logic dir, input logic stp);
        logic [7:0] p;
        p = 8'($urandom);
        p[fdctl_pkg::PORT_MTR]             = mtr;
        p[fdctl_pkg::PORT_SEL0 + drv_sel]  = sel;
        p[fdctl_pkg::PORT_SIDE]            = sd;
        p[fdctl_pkg::PORT_DIR]             = dir;
        p[fdctl_pkg::PORT_STEP]            = stp;
        return p;
    endfunction

    function automatic logic [15:0] pick_ticks();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return 16'($urandom_range(300));
        if (r < 65)
            return 16'($urandom_range(1200, 900));
        if (r < 90)
            return 16'($urandom_range(5000));
        return 16'($urandom);
    endfunction

    task automatic port_write(input logic [7:0] pv);
        send_item(fdctl_pkg::CMD_PORT_WRITE, pv, 16'($urandom), 1'($urandom));
    endtask

    task automatic ticks_pass(input logic [15:0] tc);
        send_item(fdctl_pkg::CMD_TICKS, 8'($urandom), tc, 1'($urandom));
    endtask

    // ticks, then a STEP low and a STEP high with the drive kept selected
    task automatic step_pulse(input logic dir, input logic [15:0] wait_ticks);
        ticks_pass(wait_ticks);
        port_write(port_byte(port_q[fdctl_pkg::PORT_MTR], 1'b0, 1'($urandom), dir, 1'b0));
        port_write(port_byte(port_q[fdctl_pkg::PORT_MTR], 1'b0, 1'($urandom), dir, 1'b1));
    endtask

    task automatic burst_steps(input bit polling_run);
        int   n;
        logic dir;
        if (polling_run && disk_in && ($urandom_range(3) != 0))
            send_item(fdctl_pkg::CMD_EJECT, 8'($urandom), 16'($urandom), 1'($urandom));
        port_write(port_byte(port_q[fdctl_pkg::PORT_MTR], 1'b0, 1'($urandom), 1'b1, 1'b0));
        dir = 1'($urandom);
        if (polling_run)
        begin
            // step the head out toward track zero (at most 12 steps), then rock it between two cylinders
            n = (head_cyl > 3) ? int'(head_cyl) - $urandom_range(3) : 0;
            if (n > 12)
                n = 12;
            repeat (n) step_pulse(1'b1, 16'($urandom_range(1400, 1061)));
            n = $urandom_range(4, 6);
            repeat (n)
            begin
                dir = ~dir;
                step_pulse(dir, 16'($urandom_range(1400, 1061)));
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(3) == 0)
                    dir = 1'($urandom);
                step_pulse(dir, pick_ticks());
            end
        end
    endtask

    task automatic burst_motor();
        int n;
        port_write(port_byte(1'($urandom), 1'b1, 1'($urandom), 1'($urandom), 1'($urandom)));
        port_write(port_byte(1'($urandom), 1'b0, 1'($urandom), 1'($urandom), 1'($urandom)));
        n = $urandom_range(1, 3);
        repeat (n) ticks_pass(pick_ticks());
    endtask

    task automatic burst_disk();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
            send_item($urandom_range(1) ? fdctl_pkg::CMD_INSERT : fdctl_pkg::CMD_EJECT,
                      8'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int k;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            k = $urandom_range(99);
            if (k < 15)
                send_item(2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
            else if (k < 45)
                burst_steps(1'b0);
            else if (k < 60)
                burst_steps(1'b1);
            else if (k < 80)
                burst_motor();
            else
                burst_disk();
            if ($urandom_range(19) == 0)
                wait_results_done();
        end
    endtask

    // default registers: drive zero, settle time enforced, very long motor delays
    task automatic test_directed_basics();
        port_write(8'hFF);
        ticks_pass(16'd0);
        ticks_pass(16'hFFFF);
        port_write(8'h76);
        port_write(8'h77);
        port_write(8'h74);
        port_write(8'h75);
        ticks_pass(16'(fdctl_pkg::STEP_SETTLE_DEF));
        port_write(8'h74);
        port_write(8'h75);
        ticks_pass(16'd1);
        port_write(8'h74);
        port_write(8'h75);
        ticks_pass(16'hFFFF);
        send_item(fdctl_pkg::CMD_INSERT, 8'h00, 16'h0000, 1'b1);
        send_item(fdctl_pkg::CMD_INSERT, 8'hFF, 16'hFFFF, 1'b0);
        port_write(8'h74);
        port_write(8'h75);
        send_item(fdctl_pkg::CMD_EJECT, 8'hFF, 16'hFFFF, 1'b1);
        send_item(fdctl_pkg::CMD_EJECT, 8'h00, 16'h0000, 1'b0);
        send_item(fdctl_pkg::CMD_INSERT, 8'h55, 16'hAAAA, 1'b0);
        port_write(8'h00);
        port_write(8'hFF);
        send_item(fdctl_pkg::CMD_EJECT, 8'hAA, 16'h5555, 1'b1);
    endtask

    task automatic test_id_and_no_settle();
        set_config('1, 1'b0, fdctl_pkg::ELAPSED_MAX, fdctl_pkg::ELAPSED_MAX);
        port_write(8'hFF);
        port_write(8'h3F);
        port_write(8'h3E);
        port_write(8'h3F);
        port_write(8'h3C);
        port_write(8'h3D);
        port_write(8'h3C);
        port_write(8'h3D);
        send_item(fdctl_pkg::CMD_INSERT, 8'h00, 16'h0000, 1'b0);
        port_write(8'h3C);
        port_write(8'h3D);
        send_item(fdctl_pkg::CMD_EJECT, 8'h00, 16'h0000, 1'b0);
    endtask

    task automatic test_motor_delays();
        set_config(CFG_DATA_W'(1), 1'b1, ELAPSED_W'(100), ELAPSED_W'(50));
        port_write(8'hFF);
        port_write(8'h6F);
        ticks_pass(16'd99);
        ticks_pass(16'd1);
        port_write(8'hFF);
        port_write(8'hEF);
        ticks_pass(16'd49);
        ticks_pass(16'd1);
        set_config(CFG_DATA_W'(1), 1'b1, '0, '0);
        port_write(8'hFF);
        port_write(8'h6F);
        port_write(8'hFF);
        port_write(8'hEF);
        ticks_pass(16'd0);
    endtask

    // steps past the top cylinder with no idling, then six steps down with settling not enforced
    task automatic test_cylinder_limits();
        gaps_on = 1'b0;
        set_config(CFG_DATA_W'(0), 1'b0, '0, '0);
        repeat (fdctl_pkg::MAX_CYLINDER_DEF + 2)
        begin
            port_write(port_byte(1'b1, 1'b0, 1'($urandom), 1'b0, 1'b0));
            port_write(port_byte(1'b1, 1'b0, 1'($urandom), 1'b0, 1'b1));
        end
        gaps_on = 1'b1;
        repeat (6) step_pulse(1'b1, 16'($urandom_range(20)));
    endtask

    task automatic test_random_traffic();
        set_config(CFG_DATA_W'(0), 1'b1, '0, '0);
        run_random(65);
        set_config(CFG_DATA_W'(1), 1'b0, ELAPSED_W'($urandom_range(3000, 1)),
                   ELAPSED_W'($urandom_range(3000, 1)));
        run_random(65);
        set_config({CFG_DATA_W'($urandom) & ~CFG_DATA_W'(3)} | CFG_DATA_W'(3), 1'b1,
                   ELAPSED_W'($urandom_range(70000)), ELAPSED_W'($urandom_range(5000)));
        run_random(65);
        set_config(CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1) | CFG_DATA_W'(2), 1'b1,
                   ELAPSED_W'($urandom_range(4000)), ELAPSED_W'($urandom));
        run_random(65);
    endtask

    initial
    begin
        reset_drive_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_id_and_no_settle();
        test_motor_delays();
        test_cylinder_limits();
        test_random_traffic();
        wait_results_done();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- floppy_drive_control_logic.f -----
hdl/fdctl_pkg.sv
hdl/fdctl_cfg.sv
hdl/fdctl_core.sv
hdl/floppy_drive_control_logic.sv
hdl/fdctl_checker.sv
verif/tb_floppy_drive_control_logic.sv
